[rtl/core/msort_pkg.sv]
// Shared types and constants for the merge sorter.
// No dependencies; used by msort_cell and merge_sorter_unit.
package msort_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;

	// one slot of the sorting chain: occupied flag plus stored word
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] data;
	} tok_t;

	// control broadcast to every cell
	typedef struct packed {
		logic shift;   // move held words one cell toward the head
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETTLE,
		ST_DRAIN
	} state_t;

endpackage

[rtl/core/msort_cell.sv]
// One cell of the insertion chain: keeps the smaller word, hands the larger on.
// Depends on msort_pkg.
module msort_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msort_pkg::cell_ctrl_t ctrl,
	input  msort_pkg::tok_t      in_tok,
	input  msort_pkg::tok_t      next_hold,
	output msort_pkg::tok_t      out_tok,
	output msort_pkg::tok_t      hold
);

	msort_pkg::tok_t hold_q;
	msort_pkg::tok_t pass_q;

	// compare and exchange, or shift toward the head while draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			pass_q <= '0;
		end else if (ctrl.shift) begin
			hold_q       <= next_hold;
			pass_q.valid <= 1'b0;
		end else if (in_tok.valid) begin
			if (!hold_q.valid) begin
				hold_q       <= in_tok;
				pass_q.valid <= 1'b0;
			end else if ($signed(in_tok.data) < $signed(hold_q.data)) begin
				hold_q <= in_tok;
				pass_q <= hold_q;
			end else begin
				pass_q <= in_tok;
			end
		end else begin
			pass_q.valid <= 1'b0;
		end
	end

	assign out_tok = pass_q;
	assign hold    = hold_q;

endmodule

[rtl/core/merge_sorter_unit.sv]
// Top level of the sorter: input control, cell chain and drain sequencer.
// Depends on msort_pkg and msort_cell.

// Sorts a set of signed 32-bit values into ascending order. One value is
// taken per cycle while loading; the transfer with last high closes the set.
// Values arrive at the head of a chain of CAPACITY compare-and-exchange cells,
// each keeping the smaller word and handing the larger to its neighbor. After
// the closing transfer the chain settles until the last displaced word has
// rippled to the end of the filled cells. Then the set leaves at one result
// per cycle from the head cell while out_stall is low, smallest first, with
// last_out on the final one. Values that arrive while all cells are taken are
// dropped and overflow is raised on every result of that set. No input is
// taken while a set settles or drains.
module merge_sorter_unit #(
	parameter int CAPACITY = msort_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [msort_pkg::DATA_W-1:0] value,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [msort_pkg::DATA_W-1:0] sorted_value,
	output logic                               last_out,
	output logic                               overflow
);

	localparam int CW = $clog2(CAPACITY + 1);

	msort_pkg::state_t     state_q, state_nx;
	logic [CW-1:0]         cnt_q;
	logic                  ovf_q;
	logic                  in_xfer, out_xfer, full, busy;
	msort_pkg::cell_ctrl_t ctrl;
	msort_pkg::tok_t       tok  [CAPACITY+1];
	msort_pkg::tok_t       hold [CAPACITY+1];
	logic [CAPACITY-1:0]   pend;

	assign full     = (cnt_q == CW'(CAPACITY));
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// injection at the head of the chain; dropped when full
	assign tok[0].valid = in_xfer && !full;
	assign tok[0].data  = value;

	assign hold[CAPACITY] = '0;

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		msort_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.in_tok    (tok[i]),
			.next_hold (hold[i+1]),
			.out_tok   (tok[i+1]),
			.hold      (hold[i])
		);
		assign pend[i] = tok[i+1].valid;
	end

	// words still in flight between cells
	assign busy = |pend;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			msort_pkg::ST_LOAD: begin
				if (in_xfer && last) state_nx = msort_pkg::ST_SETTLE;
			end
			msort_pkg::ST_SETTLE: begin
				if (!busy) state_nx = msort_pkg::ST_DRAIN;
			end
			msort_pkg::ST_DRAIN: begin
				if (out_xfer && cnt_q == CW'(1)) state_nx = msort_pkg::ST_LOAD;
			end
			default: state_nx = msort_pkg::ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall   = (state_q != msort_pkg::ST_LOAD);
		out_valid  = (state_q == msort_pkg::ST_DRAIN);
		ctrl.shift = out_xfer;
	end

	assign sorted_value = hold[0].data;
	assign last_out     = (cnt_q == CW'(1));
	assign overflow     = ovf_q;

	// state, element count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msort_pkg::ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_xfer) begin
				if (full) ovf_q <= 1'b1;
				else      cnt_q <= cnt_q + CW'(1);
			end else if (out_xfer) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) ovf_q <= 1'b0;
			end
		end
	end

endmodule
